/* sv/wdb_pkg.sv */
// shared types, constants and functions for the waypoint distance and bearing block
package wdb_pkg;

    localparam int CORDIC_STEPS = 18;
    localparam int MAX_STEPS    = 24;
    localparam int STEPS        = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
    localparam int IDX_W        = $clog2(MAX_STEPS);
    localparam int LATENCY      = STEPS + 3;

    localparam int IN_W      = 16;
    localparam int DIFF_W    = IN_W + 1;
    localparam int FRAC_BITS = 16;
    localparam int XW        = 36;
    localparam int ZW        = 33;

    localparam int INVK_W    = 30;
    localparam longint unsigned INVK_FULL =
        64'd652032874 + (64'd434688583 >> (2 * CORDIC_STEPS));
    localparam logic [INVK_W-1:0] INVK = INVK_W'(INVK_FULL);

    localparam int MUL_LO_W  = 18;
    localparam int MUL_HI_W  = XW - 1 - MUL_LO_W;
    localparam int PROD_W    = XW - 1 + INVK_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int DIST_SHIFT = FRAC_BITS + 30;
    localparam int DIST_W    = 17;
    localparam int DIST_WIDE_W = SUM_W - DIST_SHIFT;

    localparam int ANGLE_SHIFT = 16;
    localparam int BRG_W       = 16;
    localparam int BRG_WIDE_W  = ZW + 1 - ANGLE_SHIFT;
    localparam logic signed [BRG_WIDE_W-1:0] BRG_MAX = BRG_WIDE_W'(23040);
    localparam logic signed [BRG_WIDE_W-1:0] BRG_MIN = -BRG_WIDE_W'(23040);

    localparam logic signed [ZW-1:0] DEG90 = ZW'(754974720);

    typedef struct packed {
        logic signed [IN_W-1:0] cur_x;
        logic signed [IN_W-1:0] cur_y;
        logic signed [IN_W-1:0] dest_x;
        logic signed [IN_W-1:0] dest_y;
    } wdb_in_t;

    typedef struct packed {
        logic [DIST_W-1:0]       distance;
        logic signed [BRG_W-1:0] bearing;
    } wdb_out_t;

    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } wdb_stage_t;

    function automatic logic signed [ZW-1:0] atan_units(input logic [IDX_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = ZW'(377487360);
            5'd1:    v = ZW'(222843801);
            5'd2:    v = ZW'(117744544);
            5'd3:    v = ZW'(59768969);
            5'd4:    v = ZW'(30000467);
            5'd5:    v = ZW'(15014858);
            5'd6:    v = ZW'(7509261);
            5'd7:    v = ZW'(3754860);
            5'd8:    v = ZW'(1877459);
            5'd9:    v = ZW'(938733);
            5'd10:   v = ZW'(469367);
            5'd11:   v = ZW'(234683);
            5'd12:   v = ZW'(117342);
            5'd13:   v = ZW'(58671);
            5'd14:   v = ZW'(29335);
            5'd15:   v = ZW'(14668);
            5'd16:   v = ZW'(7334);
            5'd17:   v = ZW'(3667);
            5'd18:   v = ZW'(1833);
            5'd19:   v = ZW'(917);
            5'd20:   v = ZW'(458);
            5'd21:   v = ZW'(229);
            5'd22:   v = ZW'(115);
            5'd23:   v = ZW'(57);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* sv/waypoint_distance_and_bearing_top.sv */
// top level: distance and bearing between two points through a pipelined cordic row
//
//  port   dir  kind      content
//  start  in   strobe    request transfer, taken when busy is low
//  req    in   wdb_in_t  current and destination coordinates
//  busy   out  level     always low, the pipeline takes a transfer every cycle
//  done   out  strobe    result transfer, one cycle wide
//  res    out  wdb_out_t distance and bearing
//
//  one transfer per cycle; each request passes through the input stage, one cell per
//  cordic iteration and two multiplier stages before its result appears
//  reset clears the valid bits along the row; items in flight are dropped
//  the receiver cannot stall, so results are never held back
module waypoint_distance_and_bearing_top
    import wdb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  wdb_in_t  req,
    output logic     busy,
    output logic     done,
    output wdb_out_t res
);

    wdb_stage_t chain [0:STEPS];
    logic       accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    wdb_pre u_pre (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .out    (chain[0])
    );

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        wdb_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (IDX_W'(i)),
            .in    (chain[i]),
            .out   (chain[i+1])
        );
    end

    wdb_post u_post (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (chain[STEPS]),
        .done  (done),
        .res   (res)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result missing after request");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without request");

    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (res.bearing <= 16'sd23040) && (res.bearing >= -16'sd23040))
        else $error("bearing out of range");

    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.cur_x == req.dest_x) && (req.cur_y == req.dest_y)
        |-> ##LATENCY (res.distance == '0) && (res.bearing == '0))
        else $error("zero vector result not zero");

endmodule

/* sv/wdb_pre.sv */
// input stage: coordinate difference, zero detect and left half plane pre-rotation
module wdb_pre
    import wdb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  wdb_in_t    req,
    output wdb_stage_t out
);

    wdb_stage_t out_reg;
    wdb_stage_t out_next;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [XW-1:0]     xs;
    logic signed [XW-1:0]     ys;

    always_comb
    begin
        dx = DIFF_W'(req.dest_x) - DIFF_W'(req.cur_x);
        dy = DIFF_W'(req.dest_y) - DIFF_W'(req.cur_y);
        xs = XW'(dx) <<< FRAC_BITS;
        ys = XW'(dy) <<< FRAC_BITS;
        out_next.valid = accept;
        out_next.zero  = (dx == '0) && (dy == '0);
        out_next.x     = xs;
        out_next.y     = ys;
        out_next.z     = '0;
        if (dx[DIFF_W-1])
        begin
            if (!dy[DIFF_W-1])
            begin
                out_next.x = ys;
                out_next.y = -xs;
                out_next.z = DEG90;
            end
            else
            begin
                out_next.x = -ys;
                out_next.y = xs;
                out_next.z = -DEG90;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
        end
    end

    assign out = out_reg;

endmodule

/* sv/wdb_cell.sv */
// one vectoring cordic iteration with its pipeline register
module wdb_cell
    import wdb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] step,
    input  wdb_stage_t       in,
    output wdb_stage_t       out
);

    wdb_stage_t out_reg;
    wdb_stage_t out_next;
    logic signed [XW-1:0] x_sh;
    logic signed [XW-1:0] y_sh;
    logic signed [ZW-1:0] ang;

    always_comb
    begin
        x_sh = in.x >>> step;
        y_sh = in.y >>> step;
        ang  = atan_units(step);
        out_next.valid = in.valid;
        out_next.zero  = in.zero;
        if (!in.y[XW-1])
        begin
            out_next.x = in.x + y_sh;
            out_next.y = in.y - x_sh;
            out_next.z = in.z + ang;
        end
        else
        begin
            out_next.x = in.x - y_sh;
            out_next.y = in.y + x_sh;
            out_next.z = in.z - ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            out_reg <= out_next;
        end
    end

    assign out = out_reg;

endmodule

/* sv/wdb_post.sv */
// output stages: gain compensation in two partial products, rounding and clamping
module wdb_post
    import wdb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  wdb_stage_t in,
    output logic       done,
    output wdb_out_t   res
);

    logic                    valid1_reg;
    logic [MUL_LO_W+INVK_W-1:0] plo_reg;
    logic [MUL_LO_W+INVK_W-1:0] plo_next;
    logic [MUL_HI_W+INVK_W-1:0] phi_reg;
    logic [MUL_HI_W+INVK_W-1:0] phi_next;
    logic signed [BRG_W-1:0] brg_reg;
    logic signed [BRG_W-1:0] brg_next;
    logic                    done_reg;
    wdb_out_t                res_reg;
    wdb_out_t                res_next;

    logic [XW-2:0]                 xc;
    logic signed [ZW:0]            z_rnd;
    logic signed [BRG_WIDE_W-1:0]  brg_wide;
    logic [SUM_W-1:0]              sum;
    logic [DIST_WIDE_W-1:0]        dist_wide;

    always_comb
    begin
        xc = (in.x[XW-1] || in.zero) ? '0 : in.x[XW-2:0];
        plo_next = (MUL_LO_W+INVK_W)'(xc[MUL_LO_W-1:0]) * (MUL_LO_W+INVK_W)'(INVK);
        phi_next = (MUL_HI_W+INVK_W)'(xc[XW-2:MUL_LO_W]) * (MUL_HI_W+INVK_W)'(INVK);
        z_rnd    = {in.z[ZW-1], in.z} + ((ZW+1)'(1) <<< (ANGLE_SHIFT - 1));
        brg_wide = z_rnd[ZW:ANGLE_SHIFT];
        if (in.zero)
            brg_next = '0;
        else if (brg_wide > BRG_MAX)
            brg_next = BRG_W'(BRG_MAX);
        else if (brg_wide < BRG_MIN)
            brg_next = BRG_W'(BRG_MIN);
        else
            brg_next = BRG_W'(brg_wide);
    end

    always_comb
    begin
        sum = (SUM_W'(phi_reg) << MUL_LO_W) + SUM_W'(plo_reg)
            + (SUM_W'(1) << (DIST_SHIFT - 1));
        dist_wide = sum[SUM_W-1:DIST_SHIFT];
        if (dist_wide[DIST_WIDE_W-1:DIST_W] != '0)
            res_next.distance = '1;
        else
            res_next.distance = dist_wide[DIST_W-1:0];
        res_next.bearing = brg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid1_reg <= in.valid;
            done_reg   <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        brg_reg <= brg_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* tb/tb_waypoint_distance_and_bearing_top.sv */
// testbench for waypoint_distance_and_bearing_top: queued position pairs, bit-exact cordic predictor
module tb_waypoint_distance_and_bearing_top;
    import wdb_pkg::*;

    localparam int ITER_COUNT = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam longint unsigned GAIN_Q30 =
        64'd652032874 + (64'd434688583 >> (2 * CORDIC_STEPS));
    localparam longint QUARTER_TURN = 64'sd754974720;
    localparam longint BEARING_CLAMP = 64'sd23040;
    localparam longint unsigned DISTANCE_CLAMP = 64'd131071;
    localparam longint ARCTAN_STEP [24] = '{
        377487360, 222843801, 117744544, 59768969,
        30000467, 15014858, 7509261, 3754860,
        1877459, 938733, 469367, 234683,
        117342, 58671, 29335, 14668,
        7334, 3667, 1833, 917,
        458, 229, 115, 57
    };
    localparam int RANDOM_PAIRS = 450;
    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = LATENCY + 8;
    localparam logic signed [15:0] CORNER_VALUES [6] = '{
        16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001, 16'sh8001
    };

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    wdb_in_t  req = '0;
    logic     busy;
    logic     done;
    wdb_out_t res;

    wdb_in_t  pending_positions[$];
    wdb_out_t awaited_fixes[$];
    logic     req_taken = 1'b0;
    int       gap_left = 0;
    int       calm_left = 0;
    int       mismatches = 0;
    int       idle_cycles = 0;

    waypoint_distance_and_bearing_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .res   (res)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic wdb_out_t fix_from_positions(input wdb_in_t p);
        longint dx, dy, x, y, z, xs, ys, t, brg;
        longint unsigned dist_val;
        wdb_out_t r;
        dx = longint'($signed(p.dest_x)) - longint'($signed(p.cur_x));
        dy = longint'($signed(p.dest_y)) - longint'($signed(p.cur_y));
        r = '0;
        if (dx == 0 && dy == 0)
        begin
            return r;
        end
        x = dx <<< 16;
        y = dy <<< 16;
        z = 0;
        // left half plane: pre-rotate by a quarter turn
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = QUARTER_TURN;
            end
            else
            begin
                x = -y;
                y = t;
                z = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < ITER_COUNT; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_STEP[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_STEP[i];
            end
        end
        if (x < 0)
        begin
            x = 0;
        end
        dist_val = ($unsigned(x) * GAIN_Q30 + (64'd1 << 45)) >> 46;
        if (dist_val > DISTANCE_CLAMP)
        begin
            dist_val = DISTANCE_CLAMP;
        end
        brg = (z + 64'sd32768) >>> 16;
        if (brg > BEARING_CLAMP)
        begin
            brg = BEARING_CLAMP;
        end
        if (brg < -BEARING_CLAMP)
        begin
            brg = -BEARING_CLAMP;
        end
        r.distance = dist_val[16:0];
        r.bearing = brg[15:0];
        return r;
    endfunction

    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if (roll < 3)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    task automatic add_pair(input logic signed [15:0] cx, input logic signed [15:0] cy,
                            input logic signed [15:0] tx, input logic signed [15:0] ty);
        wdb_in_t p;
        p.cur_x = cx;
        p.cur_y = cy;
        p.dest_x = tx;
        p.dest_y = ty;
        pending_positions.push_back(p);
    endtask

    function automatic logic signed [15:0] any_coord();
        return 16'($urandom());
    endfunction

    function automatic logic signed [15:0] corner_coord();
        return CORNER_VALUES[$urandom_range(0, 5)];
    endfunction

    task automatic add_random_pair();
        int kind;
        logic signed [15:0] cx, cy, tx, ty;
        kind = $urandom_range(0, 99);
        cx = any_coord();
        cy = any_coord();
        tx = any_coord();
        ty = any_coord();
        if (kind < 50)
        begin
            add_pair(cx, cy, tx, ty);
        end
        else if (kind < 70)
        begin
            tx = cx + 16'($signed($urandom_range(0, 64)) - 32);
            ty = cy + 16'($signed($urandom_range(0, 64)) - 32);
            add_pair(cx, cy, tx, ty);
        end
        else if (kind < 80)
        begin
            case ($urandom_range(0, 3))
                0: tx = cx;
                1: ty = cy;
                2: ty = cy + (tx - cx);
                default: ty = cy - (tx - cx);
            endcase
            add_pair(cx, cy, tx, ty);
        end
        else if (kind < 90)
        begin
            add_pair(corner_coord(), corner_coord(), corner_coord(), corner_coord());
        end
        else if (kind < 94)
        begin
            add_pair(cx, cy, cx, cy);
        end
        else
        begin
            tx = cx + 16'($signed($urandom_range(0, 4096)) - 2048);
            ty = cy + 16'($signed($urandom_range(0, 4096)) - 2048);
            add_pair(cx, cy, tx, ty);
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !req_taken)
        begin
            start <= 1'b1;
        end
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_positions.size() > 0)
        begin
            req <= pending_positions.pop_front();
            start <= 1'b1;
            gap_left <= next_gap();
        end
        else
        begin
            start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        wdb_out_t want;
        req_taken <= start && !busy;
        if (rst_n)
        begin
            if (done)
            begin
                if (awaited_fixes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result transfer: distance %0d bearing %0d",
                                 res.distance, $signed(res.bearing));
                    end
                end
                else
                begin
                    want = awaited_fixes.pop_front();
                    if (res.distance !== want.distance || res.bearing !== want.bearing)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: distance exp %0d got %0d, bearing exp %0d got %0d",
                                     want.distance, res.distance,
                                     $signed(want.bearing), $signed(res.bearing));
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                awaited_fixes.push_back(fix_from_positions(req));
            end
            if ((start && !busy) || done)
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[waypoint_distance_and_bearing_top] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        // zero vectors
        add_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        add_pair(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        // axes and quadrants
        add_pair(16'sd0, 16'sd0, 16'sd100, 16'sd0);
        add_pair(16'sd0, 16'sd0, -16'sd100, 16'sd0);
        add_pair(16'sd0, 16'sd0, 16'sd0, 16'sd100);
        add_pair(16'sd0, 16'sd0, 16'sd0, -16'sd100);
        add_pair(16'sd10, 16'sd10, -16'sd30, 16'sd50);
        add_pair(16'sd10, 16'sd10, -16'sd30, -16'sd50);
        add_pair(16'sd10, 16'sd10, 16'sd40, -16'sd50);
        add_pair(16'sd0, 16'sd0, 16'sd1, 16'sd0);
        add_pair(16'sd0, 16'sd0, -16'sd1, 16'sd0);
        add_pair(16'sd0, 16'sd0, 16'sd1, 16'sd1);
        add_pair(16'sd0, 16'sd0, 16'sd0, -16'sd1);
        add_pair(16'sd0, 16'sd0, -16'sd1, -16'sd1);
        // extreme coordinates and differences
        add_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        add_pair(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        add_pair(16'sh7fff, 16'sd0, 16'sh8000, 16'sd0);
        add_pair(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
        add_pair(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        add_pair(16'sh7fff, 16'sd0, 16'sh8000, -16'sd1);
        add_pair(16'sh7fff, 16'sd0, 16'sh8000, 16'sd1);
        add_pair(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        add_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        for (int n = 0; n < RANDOM_PAIRS; n++)
        begin
            add_random_pair();
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_positions.size() != 0 || start)
        begin
            @(posedge clk);
        end
        while (awaited_fixes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("[waypoint_distance_and_bearing_top] OK");
        end
        else
        begin
            $display("[waypoint_distance_and_bearing_top] ERROR");
        end
        $finish;
    end

endmodule

/* waypoint_distance_and_bearing_top.f */
sv/wdb_pkg.sv
sv/wdb_pre.sv
sv/wdb_cell.sv
sv/wdb_post.sv
sv/waypoint_distance_and_bearing_top.sv
tb/tb_waypoint_distance_and_bearing_top.sv
